>>> rtl/bc_pkg.sv
// Shared widths and sequencer state encoding for the binomial coefficient unit.
package bc_pkg;

   localparam int COUNT_W   = 6;
   localparam int COEF_W    = 60;
   localparam int PROD_W    = COEF_W + COUNT_W;
   localparam int DIV_CNT_W = $clog2(PROD_W);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

>>> rtl/binomial_coefficient_unit.sv
// Binomial coefficient unit: exact C(n,k) by a shared multiply step and a bit-serial divider.
//
// Each request gives n and k and returns exactly one response carrying the exact
// binomial coefficient C(n,k), or zero when k exceeds n. The product is built with
// r = r * (n - j + m) / m for m = 1 .. j, where j is the smaller of k and n - k.
// Each step is one multiply followed by a restoring divider that retires one quotient
// bit per cycle across the 66-bit product; j is at most 31. The block handles
// one request at a time: req_stall stays high from the accepted transfer until the
// response transfer completes.
module binomial_coefficient_unit
   import bc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [COUNT_W-1:0]  req_total_count,
   input  logic [COUNT_W-1:0]  req_chosen_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COEF_W-1:0]   rsp_coefficient
);

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   n_ff, n_in;
   logic [COUNT_W-1:0]   j_ff, j_in;
   logic [COUNT_W-1:0]   m_ff, m_in;
   logic [COEF_W-1:0]    r_ff, r_in;
   logic [PROD_W-1:0]    dvd_ff, dvd_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic [COUNT_W-1:0]   diff;
   logic [COUNT_W-1:0]   j_req;
   logic [COUNT_W-1:0]   num;
   logic [COUNT_W:0]     trial;
   logic                 q_bit;
   logic [COUNT_W:0]     trial_sub;
   logic [PROD_W-1:0]    dvd_step;

   assign diff      = req_total_count - req_chosen_count;
   assign j_req     = (req_chosen_count > diff) ? diff : req_chosen_count;
   assign num       = n_ff - j_ff + m_ff;
   assign trial     = {rem_ff, dvd_ff[PROD_W-1]};
   assign q_bit     = (trial >= {1'b0, m_ff});
   assign trial_sub = trial - {1'b0, m_ff};
   assign dvd_step  = {dvd_ff[PROD_W-2:0], q_bit};

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_coefficient = r_ff;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      j_in     = j_ff;
      m_in     = m_ff;
      r_in     = r_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in = req_total_count;
               j_in = j_req;
               m_in = COUNT_W'(1);
               if (req_chosen_count > req_total_count) begin
                  r_in     = '0;
                  state_in = ST_DONE;
               end else if (j_req == '0) begin
                  r_in     = COEF_W'(1);
                  state_in = ST_DONE;
               end else begin
                  r_in     = COEF_W'(1);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            dvd_in   = PROD_W'(r_ff) * PROD_W'(num);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dvd_in = dvd_step;
            rem_in = q_bit ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               r_in = dvd_step[COEF_W-1:0];
               if (m_ff == j_ff) begin
                  state_in = ST_DONE;
               end else begin
                  m_in     = m_ff + COUNT_W'(1);
                  state_in = ST_MUL;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      j_ff   <= j_in;
      m_ff   <= m_in;
      r_ff   <= r_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

endmodule

>>> dv/binomial_coefficient_unit_test.sv
// Self-checking testbench for the binomial coefficient unit with random stimulus and stalls.
`timescale 1ns / 1ps

module binomial_coefficient_unit_test
   import bc_pkg::*;
();

   typedef struct packed {
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] chosen;
      logic               drain;
   } choose_request_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [COUNT_W-1:0]  req_total_count = '0;
   logic [COUNT_W-1:0]  req_chosen_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COEF_W-1:0]   rsp_coefficient;

   choose_request_type  pending_requests[$];
   logic [COEF_W-1:0]   expected_coefficients[$];

   int accepted_count = 0;
   int checked_count = 0;
   int error_count = 0;
   int zero_count = 0;
   int widest_count = 0;

   binomial_coefficient_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_total_count  (req_total_count),
      .req_chosen_count (req_chosen_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coefficient  (rsp_coefficient)
   );

   always #5 clock = ~clock;

   function automatic int steps_of(input logic [COUNT_W-1:0] n, input logic [COUNT_W-1:0] k);
      if (k > n)
         return 0;
      return (k > n - k) ? int'(n - k) : int'(k);
   endfunction

   function automatic logic [COEF_W-1:0] binomial_of(input logic [COUNT_W-1:0] n,
                                                     input logic [COUNT_W-1:0] k);
      logic [127:0] acc;
      int           j;
      if (k > n)
         return '0;
      j = steps_of(n, k);
      acc = 128'd1;
      for (int m = 1; m <= j; m++)
         acc = acc * (int'(n) - j + m) / m;
      return acc[COEF_W-1:0];
   endfunction

   // driver
   always @(posedge clock) begin
      choose_request_type next_req;
      logic               quiet;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_coefficients.push_back(binomial_of(req_total_count, req_chosen_count));
            accepted_count++;
            if (req_chosen_count > req_total_count)
               zero_count++;
            if (steps_of(req_total_count, req_chosen_count) >= 28)
               widest_count++;
         end
         if (!req_valid || !req_stall) begin
            quiet = (accepted_count >= 120) && (accepted_count < 170);
            if (pending_requests.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_requests[0].drain && expected_coefficients.size() != 0) begin
               req_valid <= 1'b0;
            end else if (!quiet && ($urandom_range(99, 0) < 15)) begin
               req_valid <= 1'b0;
            end else begin
               next_req = pending_requests.pop_front();
               req_valid        <= 1'b1;
               req_total_count  <= next_req.total;
               req_chosen_count <= next_req.chosen;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      logic [COEF_W-1:0] want;
      logic              quiet;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_coefficients.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected transfer: coefficient %0d", rsp_coefficient);
         end else begin
            want = expected_coefficients.pop_front();
            if (rsp_coefficient !== want) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch on response %0d: expected %0d, actual %0d",
                           checked_count, want, rsp_coefficient);
            end
         end
         checked_count++;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         quiet = (checked_count >= 120) && (checked_count < 170);
         rsp_stall <= !quiet && ($urandom_range(99, 0) < 15);
      end
   end

   task automatic add_request(input int n, input int k, input bit drain = 1'b0);
      choose_request_type r;
      r.total  = n[COUNT_W-1:0];
      r.chosen = k[COUNT_W-1:0];
      r.drain  = drain;
      pending_requests.push_back(r);
   endtask

   initial begin
      int n;
      int k;
      int d;
      int sel;

      add_request(0, 0);
      add_request(63, 0);
      add_request(63, 63);
      add_request(63, 31);
      add_request(63, 32);
      add_request(0, 63);
      add_request(0, 1);
      add_request(62, 63);
      add_request(5, 63);
      add_request(1, 0);
      add_request(1, 1);
      add_request(63, 1);
      add_request(63, 62);
      add_request(2, 1);
      add_request(10, 5);
      add_request(40, 20);
      add_request(62, 31);
      add_request(61, 30);
      add_request(42, 21);
      add_request(21, 42);

      for (int i = 0; i < 270; i++) begin
         sel = $urandom_range(99, 0);
         n = $urandom_range(63, 0);
         if (sel < 10) begin
            k = (n < 63) ? $urandom_range(63, n + 1) : $urandom_range(63, 0);
         end else if (sel < 14) begin
            n = $urandom_range(63, 56);
            k = n / 2 + $urandom_range(2, 0);
         end else if (sel < 24) begin
            k = $urandom_range(63, 0);
         end else begin
            d = $urandom_range(6, 0);
            if ($urandom_range(1, 0))
               k = (d <= n) ? d : n;
            else
               k = (n >= d) ? n - d : 0;
         end
         add_request(n, k, (i == 40) || (i == 200));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_coefficients.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      if (expected_coefficients.size() != 0)
         error_count++;
      $display("covered %0d requests (%0d with k above n, %0d with 28 or more steps)",
               accepted_count, zero_count, widest_count);
      $display("checked %0d responses, %0d errors", checked_count, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d responses outstanding", expected_coefficients.size());
      $display("FAIL");
      $finish;
   end

endmodule
